[hdl/gle_pkg.sv]
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types, message constants and byte helpers for the grid LED update
// encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

    localparam int GRID_SIDE_DEF = 9;
    localparam int Q_DEPTH       = 2;
    localparam int HDR_LEN       = 6;

    // command codes on the func input
    localparam logic [1:0] FUNC_SET     = 2'd0;
    localparam logic [1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [1:0] FUNC_SESSION = 2'd2;

    localparam logic [7:0] CMD_SET     = 8'h0B;
    localparam logic [7:0] CMD_CLEAR   = 8'h0E;
    localparam logic [7:0] CMD_SESSION = 8'h22;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam logic [7:0] PAD_BASE     = 8'd11;
    localparam logic [7:0] PAD_ROW_STEP = 8'd10;
    localparam logic [7:0] PAD_TOP_BASE = 8'd104;

    localparam logic [3:0] LAST_SET   = 4'd11;
    localparam logic [3:0] LAST_SHORT = 4'd8;
    localparam logic [3:0] LAST_ERR   = 4'd0;

    localparam logic [7:0] MSG_HEAD [HDR_LEN] = '{8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18};

    typedef enum logic [1:0] {
        K_ERR,
        K_SET,
        K_CLEAR,
        K_SESSION
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] pad;
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } t_job;

    // floor(v*63/255) via reciprocal: x/255 == (x + (x>>8) + 1) >> 8 for small x
    function automatic logic [5:0] scale63(input logic [7:0] v);
        logic [13:0] p;
        logic [14:0] s;
        p = 14'(v) * 14'd63;
        s = 15'(p) + 15'(p >> 8) + 15'd1;
        return s[13:8];
    endfunction

    function automatic logic [3:0] last_pos(input t_kind kind);
        logic [3:0] l;
        unique case (kind)
            K_ERR:   l = LAST_ERR;
            K_SET:   l = LAST_SET;
            default: l = LAST_SHORT;
        endcase
        return l;
    endfunction

    // byte at position k of the message described by j
    function automatic logic [7:0] msg_byte(input t_job j, input logic [3:0] k);
        logic [7:0] b;
        logic       is_set;
        is_set = (j.kind == K_SET);
        b      = SYSEX_END;
        if (j.kind == K_ERR) begin
            b = 8'h00;
        end else if (k < 4'(HDR_LEN)) begin
            b = MSG_HEAD[k[2:0]];
        end else begin
            case (k)
                4'd6: begin
                    if (is_set) b = CMD_SET;
                    else if (j.kind == K_CLEAR) b = CMD_CLEAR;
                    else b = CMD_SESSION;
                end
                4'd7:    b = is_set ? j.pad : 8'h00;
                4'd8:    b = is_set ? {2'b00, j.red} : SYSEX_END;
                4'd9:    b = {2'b00, j.green};
                4'd10:   b = {2'b00, j.blue};
                default: b = SYSEX_END;
            endcase
        end
        return b;
    endfunction

endpackage

[hdl/gle_front.sv]
// ----------------------------------------------------------------------------
// gle_front
// Accepts commands, checks coordinates, looks up and updates the shadow grid
// and hands a message job to the back end.
// ----------------------------------------------------------------------------
module gle_front #(
    parameter int GRID_SIDE = gle_pkg::GRID_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_func,
    input  logic [3:0]    i_column,
    input  logic [3:0]    i_row,
    input  logic [23:0]   i_color,
    input  logic          i_port_open,
    output logic          o_job_push,
    output gle_pkg::t_job o_job,
    input  logic          i_job_full
);
    import gle_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = $clog2(CELLS);
    localparam logic [4:0] MAX_POS = 5'(GRID_SIDE - 1);

    logic [23:0]       r_shadow [CELLS];
    logic [23:0]       r_rd_color;
    logic [CELLS-1:0]  r_lit;
    logic              r_valid;
    logic [1:0]        r_func;
    logic [3:0]        r_col;
    logic [3:0]        r_row;
    logic [23:0]       r_color;
    logic              r_bad;
    logic [CELL_W-1:0] r_idx;

    logic              accept;
    logic              in_bad;
    logic [CELL_W-1:0] in_idx;
    logic [23:0]       old_color;
    logic              changed;
    logic              is_set;
    logic              proceed;
    logic              wr_en;
    logic [7:0]        pad;

    assign accept = i_push && !r_valid;
    assign o_full = r_valid;

    assign in_bad = (i_func == FUNC_SET) &&
                    (({1'b0, i_column} > MAX_POS) || ({1'b0, i_row} > MAX_POS) ||
                     (({1'b0, i_column} == MAX_POS) && ({1'b0, i_row} == MAX_POS)));
    assign in_idx = CELL_W'(32'(i_row) * GRID_SIDE + 32'(i_column));

    assign is_set    = (r_func == FUNC_SET);
    assign old_color = r_lit[r_idx] ? r_rd_color : 24'h0;
    assign changed   = (r_color != old_color);

    always_comb begin
        o_job_push = 1'b0;
        if (r_valid) begin
            if (r_bad) begin
                o_job_push = 1'b1;
            end else if (i_port_open) begin
                o_job_push = (is_set && changed) || (r_func == FUNC_CLEAR) ||
                             (r_func == FUNC_SESSION);
            end
        end
    end

    assign proceed = r_valid && (!o_job_push || !i_job_full);
    assign wr_en   = proceed && is_set && !r_bad;

    // top strip pads are numbered apart from the main grid
    assign pad = ({1'b0, r_row} == MAX_POS) ? (PAD_TOP_BASE + 8'(r_col))
                 : (PAD_BASE + 8'(r_row) * PAD_ROW_STEP + 8'(r_col));

    always_comb begin
        o_job.pad   = pad;
        o_job.red   = scale63(r_color[23:16]);
        o_job.green = scale63(r_color[15:8]);
        o_job.blue  = scale63(r_color[7:0]);
        if (r_bad) o_job.kind = K_ERR;
        else if (is_set) o_job.kind = K_SET;
        else if (r_func == FUNC_CLEAR) o_job.kind = K_CLEAR;
        else o_job.kind = K_SESSION;
    end

    // shadow color store, read at accept, written when the item retires
    always_ff @(posedge i_clk) begin
        if (accept) r_rd_color <= r_shadow[in_idx];
        if (wr_en) r_shadow[r_idx] <= r_color;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_col   <= i_column;
            r_row   <= i_row;
            r_color <= i_color;
            r_bad   <= in_bad;
            r_idx   <= in_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lit   <= '0;
        end else begin
            if (accept) r_valid <= 1'b1;
            else if (proceed) r_valid <= 1'b0;
            if (wr_en) r_lit[r_idx] <= 1'b1;
            else if (proceed && (r_func == FUNC_CLEAR)) r_lit <= '0;
        end
    end

endmodule

[hdl/gle_queue.sv]
// ----------------------------------------------------------------------------
// gle_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module gle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gle_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output gle_pkg::t_job o_data,
    output logic          o_empty
);
    import gle_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

[hdl/gle_back.sv]
// ----------------------------------------------------------------------------
// gle_back
// Walks a queued job byte by byte into the result register.
// ----------------------------------------------------------------------------
module gle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  gle_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [7:0]    o_out_byte,
    output logic          o_last,
    output logic          o_status
);
    import gle_pkg::*;

    logic [3:0] r_cnt;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_status;
    logic       load;
    logic       at_last;

    assign load      = !i_job_empty && (!r_out_valid || i_pop);
    assign at_last   = (r_cnt == last_pos(i_job.kind));
    assign o_job_pop = load && at_last;

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_status   = r_out_status;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= msg_byte(i_job, r_cnt);
            r_out_last   <= at_last;
            r_out_status <= (i_job.kind == K_ERR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_cnt       <= at_last ? 4'd0 : r_cnt + 4'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/grid_led_update_encoder.sv]
// path: front register, job queue, byte output register; the front takes no new
// command until the current one retires (shadow read, then update); bytes leave
// one a cycle while the receiver pops, 12 for a pixel change, 9 for clear or
// session, 1 for a coordinate error; a 2-entry job queue decouples the two ends
// reset: synchronous active low, clears port_open, lit flags, queue and byte
// counter; the shadow color store is not cleared (unlit pads read as black)
// ----------------------------------------------------------------------------
// grid_led_update_encoder
// Shadow LED grid that turns pixel, clear and session commands into
// system-exclusive byte messages.
// ----------------------------------------------------------------------------
module grid_led_update_encoder #(
    parameter int GRID_SIDE = gle_pkg::GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_column,
    input  logic [3:0]  i_row,
    input  logic [23:0] i_color,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_status
);
    import gle_pkg::*;

    logic r_port_open;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    t_job job_in;
    t_job job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_open <= 1'b0;
        end else if (i_cfg_we) begin
            r_port_open <= i_cfg_wdata;
        end
    end

    gle_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_color     (i_color),
        .i_port_open (r_port_open),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    gle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    gle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule

[tb/sv/gle_checker.sv]
// ----------------------------------------------------------------------------
// gle_checker
// Watches the command and byte channels of the grid LED update encoder,
// keeps its own shadow grid to work out the expected message bytes and
// compares every byte transfer against the oldest expected one.
// ----------------------------------------------------------------------------
module gle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_column,
    input  logic [3:0]  i_row,
    input  logic [23:0] i_color,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last,
    input  logic        i_status,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE     = gle_pkg::GRID_SIDE_DEF;
    localparam int CELLS    = SIDE * SIDE;
    localparam int HEAD_LEN = 6;

    localparam logic [7:0] SYSEX_HEAD [HEAD_LEN] = '{8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18};
    localparam logic [7:0] SYSEX_EOX     = 8'hF7;
    localparam logic [7:0] OP_SET_PIXEL  = 8'h0B;
    localparam logic [7:0] OP_CLEAR      = 8'h0E;
    localparam logic [7:0] OP_SESSION    = 8'h22;
    localparam int         GRID_PAD_BASE = 11;
    localparam int         GRID_PAD_STEP = 10;
    localparam int         TOP_PAD_BASE  = 104;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
    } t_sysex_byte;

    t_sysex_byte sysex_q [$];
    logic [23:0] shadow_rgb [CELLS];
    logic        lit [CELLS];
    logic        r_port_open;
    int          fails = 0;

    function automatic logic [7:0] to_six_bit(input logic [7:0] v);
        int unsigned p;
        p = int'(v) * 63;
        return 8'(p / 255);
    endfunction

    task automatic add_expected(input t_sysex_byte e);
        sysex_q = {sysex_q, e};
    endtask

    task automatic queue_message(input logic [7:0] body [5], input int blen);
        int          total;
        logic [7:0]  b;
        total = HEAD_LEN + blen + 1;
        if (!r_port_open) return;
        for (int k = 0; k < total; k++) begin
            if (k < HEAD_LEN) b = SYSEX_HEAD[k];
            else if (k < HEAD_LEN + blen) b = body[k - HEAD_LEN];
            else b = SYSEX_EOX;
            add_expected('{data: b, last: (k == total - 1), status: 1'b0});
        end
    endtask

    task automatic predict_command(input logic [1:0] func, input logic [3:0] col,
                                   input logic [3:0] row, input logic [23:0] rgb);
        int          slot;
        logic [23:0] prev;
        logic [7:0]  body [5];
        body = '{default: 8'h00};
        case (func)
            gle_pkg::FUNC_SET: begin
                if (col > SIDE - 1 || row > SIDE - 1 || (col == SIDE - 1 && row == SIDE - 1)) begin
                    add_expected('{data: 8'h00, last: 1'b1, status: 1'b1});
                end else begin
                    slot = int'(row) * SIDE + int'(col);
                    prev = lit[slot] ? shadow_rgb[slot] : 24'h0;
                    if (rgb != prev) begin
                        body[0] = OP_SET_PIXEL;
                        // top strip pads are numbered apart from the main grid
                        if (row == SIDE - 1) body[1] = 8'(TOP_PAD_BASE + int'(col));
                        else body[1] = 8'(GRID_PAD_BASE + GRID_PAD_STEP * int'(row) + int'(col));
                        body[2] = to_six_bit(rgb[23:16]);
                        body[3] = to_six_bit(rgb[15:8]);
                        body[4] = to_six_bit(rgb[7:0]);
                        queue_message(body, 5);
                    end
                    shadow_rgb[slot] = rgb;
                    lit[slot]        = 1'b1;
                end
            end
            gle_pkg::FUNC_CLEAR: begin
                for (int k = 0; k < CELLS; k++) lit[k] = 1'b0;
                body[0] = OP_CLEAR;
                queue_message(body, 2);
            end
            gle_pkg::FUNC_SESSION: begin
                body[0] = OP_SESSION;
                queue_message(body, 2);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_sysex_byte want;
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) lit[k] = 1'b0;
            r_port_open = 1'b0;
            sysex_q.delete();
        end else begin
            if (i_cfg_we) r_port_open = i_cfg_wdata;
            // result side first: a command accepted now cannot show up at this edge
            if (i_pop && !i_empty) begin
                if (sysex_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result with nothing expected: byte %02h last %b status %b",
                                 $time, i_out_byte, i_last, i_status);
                    fails++;
                end else begin
                    want = sysex_q.pop_front();
                    if (i_out_byte !== want.data || i_last !== want.last ||
                        i_status !== want.status) begin
                        if (fails < 10)
                            $display("%0t: expected %02h/%b/%b, got %02h/%b/%b", $time,
                                     want.data, want.last, want.status,
                                     i_out_byte, i_last, i_status);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full) predict_command(i_func, i_column, i_row, i_color);
        end
        o_pending    <= sysex_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel, clear and session commands into the grid LED update encoder
// with random gaps and stalls on both sides, switches the port open and
// closed between phases, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gle_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int         EDGE_IDX  = GRID_SIDE_DEF - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        push;
    logic        full;
    logic [1:0]  i_func;
    logic [3:0]  i_column;
    logic [3:0]  i_row;
    logic [23:0] i_color;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_status;

    int          fail_cnt;
    int          pending_cnt;

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          rx_hold    = 0;

    bit          have_last  = 1'b0;
    logic [3:0]  last_col;
    logic [3:0]  last_row;
    logic [23:0] last_rgb;

    always #10 i_clk = ~i_clk;

    grid_led_update_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_color     (i_color),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    gle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_full       (full),
        .i_func       (i_func),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_color      (i_color),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_byte   (o_out_byte),
        .i_last       (o_last),
        .i_status     (o_status),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    // push stays high on return so back-to-back commands need no gap
    task automatic send_cmd(input logic [1:0] f, input logic [3:0] c, input logic [3:0] r,
                            input logic [23:0] rgb);
        push     <= 1'b1;
        i_func   <= f;
        i_column <= c;
        i_row    <= r;
        i_color  <= rgb;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // pending count is registered in the checker, so step the clock before looking at it
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        // commands with no bytes may still be inside the block
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_port_open(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int          done;
        int          pick;
        logic [1:0]  f;
        logic [3:0]  c;
        logic [3:0]  r;
        logic [23:0] rgb;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(0, 99);
            f    = FUNC_SET;
            c    = 4'($urandom);
            r    = 4'($urandom);
            rgb  = 24'($urandom);
            if (pick < 8) begin
                case ($urandom_range(0, 2))
                    0:       c = 4'($urandom_range(9, 15));
                    1:       r = 4'($urandom_range(9, 15));
                    default: begin
                        c = 4'(EDGE_IDX);
                        r = 4'(EDGE_IDX);
                    end
                endcase
            end else if (pick < 13) begin
                f = FUNC_CLEAR;
            end else if (pick < 17) begin
                f = FUNC_SESSION;
            end else if (pick < 20) begin
                f = FUNC_NONE;
            end else if (pick < 32 && have_last) begin
                // same pixel, same color: shadow rewrite with no message unless a clear came between
                c   = last_col;
                r   = last_row;
                rgb = last_rgb;
            end else begin
                do begin
                    c = 4'($urandom_range(0, EDGE_IDX));
                    r = 4'($urandom_range(0, EDGE_IDX));
                end while (c == EDGE_IDX && r == EDGE_IDX);
                case ($urandom_range(0, 5))
                    0:       rgb = 24'hFFFFFF;
                    1:       rgb = 24'h000000;
                    2:       rgb = rgb & 24'($urandom);
                    default: ;
                endcase
            end
            send_cmd(f, c, r, rgb);
            if (pick >= 20) begin
                have_last = 1'b1;
                last_col  = c;
                last_row  = r;
                last_rgb  = rgb;
            end
            if (f != FUNC_NONE) done++;
            if (tx_idle_en && $urandom_range(0, 3) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    endtask

    initial begin : receiver
        int hold_len;
        pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                hold_len = rx_hold;
                rx_hold  = 0;
                pop <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("grid_led_update_encoder: mismatch");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        push        <= 1'b0;
        i_func      <= FUNC_SET;
        i_column    <= 4'd0;
        i_row       <= 4'd0;
        i_color     <= 24'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_port_open(1'b0);

        // port closed: only the coordinate error comes out
        send_cmd(FUNC_SESSION, 4'h5, 4'hA, 24'h5A5A5A);
        send_cmd(FUNC_CLEAR, 4'hF, 4'hF, 24'hFFFFFF);
        send_cmd(FUNC_SET, 4'd12, 4'd3, 24'h00FF00);
        send_cmd(FUNC_SET, 4'd2, 4'd2, 24'h123456);
        wait_drained();
        write_port_open(1'b1);

        send_cmd(FUNC_SET, 4'd2, 4'd2, 24'h123456);
        send_cmd(FUNC_SET, 4'd0, 4'd0, 24'hFFFFFF);
        send_cmd(FUNC_SET, 4'd0, 4'd0, 24'hFFFFFF);
        send_cmd(FUNC_SET, 4'd8, 4'd7, 24'h000000);
        send_cmd(FUNC_SET, 4'd8, 4'd7, 24'h050403);
        send_cmd(FUNC_SET, 4'd0, 4'd8, 24'hFF0000);
        send_cmd(FUNC_SET, 4'd7, 4'd8, 24'h00FF00);
        send_cmd(FUNC_SET, 4'd8, 4'd0, 24'h0000FF);
        send_cmd(FUNC_SET, 4'd8, 4'd8, 24'h777777);
        send_cmd(FUNC_SET, 4'd15, 4'd0, 24'h111111);
        send_cmd(FUNC_SET, 4'd0, 4'd15, 24'h222222);
        send_cmd(FUNC_SET, 4'd9, 4'd9, 24'h333333);
        send_cmd(FUNC_SET, 4'd15, 4'd15, 24'hFFFFFF);
        send_cmd(FUNC_SET, 4'd4, 4'd5, 24'h808080);
        send_cmd(FUNC_SET, 4'd5, 4'd4, 24'hFEFDFC);
        send_cmd(FUNC_CLEAR, 4'hF, 4'hA, 24'hA5A5A5);
        send_cmd(FUNC_SET, 4'd0, 4'd0, 24'hFFFFFF);
        send_cmd(FUNC_SET, 4'd4, 4'd5, 24'h000000);
        send_cmd(FUNC_SESSION, 4'h0, 4'h0, 24'h000000);
        send_cmd(FUNC_NONE, 4'd3, 4'd3, 24'hABCDEF);
        send_cmd(FUNC_SET, 4'd3, 4'd3, 24'h000001);

        run_random(40);
        // long receiver hold while commands keep coming, so the block backs up
        tx_idle_en = 1'b0;
        rx_hold    = 400;
        run_random(20);
        tx_idle_en = 1'b1;
        wait_drained();
        run_random(90);

        wait_drained();
        write_port_open(1'b0);
        run_random(40);
        wait_drained();
        write_port_open(1'b1);
        run_random(100);

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(40);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("grid_led_update_encoder: match");
        end else begin
            $display("grid_led_update_encoder: mismatch");
        end
        $finish;
    end

endmodule
